/* hdl/irpwd_pkg.sv */
`default_nettype none
package irpwd_pkg;

  localparam int unsigned WIDTH_W        = 16;
  localparam int unsigned CMD_W          = 32;
  localparam int unsigned FRAME_BITS_DEF = 32;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 3'd6;

  localparam logic [WIDTH_W-1:0] TOLERANCE_RST = 16'd5;
  localparam logic [WIDTH_W-1:0] START_RST     = 16'd45;
  localparam logic [WIDTH_W-1:0] END_RST       = 16'd395;
  localparam logic [WIDTH_W-1:0] REPEAT_RST    = 16'd959;
  localparam logic [WIDTH_W-1:0] ZERO_RST      = 16'd6;
  localparam logic [WIDTH_W-1:0] ONE_RST       = 16'd17;
  localparam logic [WIDTH_W-1:0] SEPARATOR_RST = 16'd23;

  typedef struct packed {
    logic [WIDTH_W-1:0] tolerance;
    logic [WIDTH_W-1:0] start_width;
    logic [WIDTH_W-1:0] end_width;
    logic [WIDTH_W-1:0] repeat_width;
    logic [WIDTH_W-1:0] zero_width;
    logic [WIDTH_W-1:0] one_width;
    logic [WIDTH_W-1:0] separator_width;
  } cfg_t;

  typedef enum logic [2:0] {
    PULSE_NONE,
    PULSE_START,
    PULSE_ONE,
    PULSE_ZERO,
    PULSE_END,
    PULSE_REPEAT,
    PULSE_SEPARATOR
  } pulse_class_t;

endpackage
`default_nettype wire

/* hdl/irpwd_classify.sv */
`default_nettype none
module irpwd_classify (
  input  wire logic [irpwd_pkg::WIDTH_W-1:0] width,
  input  wire irpwd_pkg::cfg_t               cfg,
  output irpwd_pkg::pulse_class_t            pulse_class
);

  function automatic logic in_window(
    input logic [irpwd_pkg::WIDTH_W-1:0] w,
    input logic [irpwd_pkg::WIDTH_W-1:0] nominal,
    input logic [irpwd_pkg::WIDTH_W-1:0] tol
  );
    logic [irpwd_pkg::WIDTH_W:0] w_plus_t;
    logic [irpwd_pkg::WIDTH_W:0] n_plus_t;
    w_plus_t  = {1'b0, w} + {1'b0, tol};
    n_plus_t  = {1'b0, nominal} + {1'b0, tol};
    in_window = (w_plus_t > {1'b0, nominal}) && ({1'b0, w} < n_plus_t);
  endfunction

  always_comb begin
    if (in_window(width, cfg.start_width, cfg.tolerance)) begin
      pulse_class = irpwd_pkg::PULSE_START;
    end else if (in_window(width, cfg.one_width, cfg.tolerance)) begin
      pulse_class = irpwd_pkg::PULSE_ONE;
    end else if (in_window(width, cfg.zero_width, cfg.tolerance)) begin
      pulse_class = irpwd_pkg::PULSE_ZERO;
    end else if (in_window(width, cfg.end_width, cfg.tolerance)) begin
      pulse_class = irpwd_pkg::PULSE_END;
    end else if (in_window(width, cfg.repeat_width, cfg.tolerance)) begin
      pulse_class = irpwd_pkg::PULSE_REPEAT;
    end else if (in_window(width, cfg.separator_width, cfg.tolerance)) begin
      pulse_class = irpwd_pkg::PULSE_SEPARATOR;
    end else begin
      pulse_class = irpwd_pkg::PULSE_NONE;
    end
  end

endmodule
`default_nettype wire

/* hdl/ir_pulse_width_frame_decoder.sv */
// A separator beat taken at the input passes the input register to the result register.
// Throughput: one pulse beat per cycle; the input register stalls only while
// the result register is full and stalled.
// Reset (synchronous, active high): frame closed, shift word, latched command and
// repeat flag cleared, configuration back to its default widths.
`default_nettype none
module ir_pulse_width_frame_decoder #(
  parameter int unsigned FRAME_BITS = irpwd_pkg::FRAME_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [irpwd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [irpwd_pkg::WIDTH_W-1:0]     cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [irpwd_pkg::WIDTH_W-1:0]     pulse_width,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [irpwd_pkg::CMD_W-1:0]            command_word,
  output logic                                   repeat_seen
);

  localparam int unsigned CNT_W = $clog2(FRAME_BITS + 2);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BITS);
  localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(FRAME_BITS + 1);

  irpwd_pkg::cfg_t                cfg;
  logic                           s1_valid;
  logic [irpwd_pkg::WIDTH_W-1:0]  s1_width;
  irpwd_pkg::pulse_class_t        s1_class;
  logic                           advance;

  logic [FRAME_BITS-1:0]          bit_shift;
  logic [FRAME_BITS-1:0]          bit_shift_next;
  logic [CNT_W-1:0]               bit_count;
  logic [CNT_W-1:0]               bit_count_next;
  logic                           frame_started;
  logic                           frame_started_next;
  logic                           repeat_held;
  logic                           repeat_held_next;
  logic [irpwd_pkg::CMD_W-1:0]    latched_command;
  logic [irpwd_pkg::CMD_W-1:0]    latched_command_next;
  logic                           emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance       <= irpwd_pkg::TOLERANCE_RST;
      cfg.start_width     <= irpwd_pkg::START_RST;
      cfg.end_width       <= irpwd_pkg::END_RST;
      cfg.repeat_width    <= irpwd_pkg::REPEAT_RST;
      cfg.zero_width      <= irpwd_pkg::ZERO_RST;
      cfg.one_width       <= irpwd_pkg::ONE_RST;
      cfg.separator_width <= irpwd_pkg::SEPARATOR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        irpwd_pkg::REG_TOLERANCE: cfg.tolerance       <= cfg_data;
        irpwd_pkg::REG_START:     cfg.start_width     <= cfg_data;
        irpwd_pkg::REG_END:       cfg.end_width       <= cfg_data;
        irpwd_pkg::REG_REPEAT:    cfg.repeat_width    <= cfg_data;
        irpwd_pkg::REG_ZERO:      cfg.zero_width      <= cfg_data;
        irpwd_pkg::REG_ONE:       cfg.one_width       <= cfg_data;
        irpwd_pkg::REG_SEPARATOR: cfg.separator_width <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_width <= pulse_width;
    end
  end

  irpwd_classify u_classify (
    .width       (s1_width),
    .cfg         (cfg),
    .pulse_class (s1_class)
  );

  always_comb begin
    bit_shift_next       = bit_shift;
    bit_count_next       = bit_count;
    frame_started_next   = frame_started;
    repeat_held_next     = repeat_held;
    latched_command_next = latched_command;
    emit                 = 1'b0;
    case (s1_class)
      irpwd_pkg::PULSE_START: begin
        bit_count_next     = '0;
        frame_started_next = 1'b1;
      end
      irpwd_pkg::PULSE_ONE, irpwd_pkg::PULSE_ZERO: begin
        if (frame_started) begin
          if (bit_count < CNT_FULL) begin
            bit_shift_next = FRAME_BITS'({bit_shift, s1_class == irpwd_pkg::PULSE_ONE});
            bit_count_next = bit_count + 1'b1;
          end else begin
            bit_count_next = CNT_OVER;
          end
        end
      end
      irpwd_pkg::PULSE_END: begin
        if (frame_started && bit_count == CNT_FULL) begin
          latched_command_next = irpwd_pkg::CMD_W'(bit_shift);
        end else begin
          latched_command_next = '0;
        end
        repeat_held_next   = 1'b0;
        frame_started_next = 1'b0;
        bit_count_next     = '0;
      end
      irpwd_pkg::PULSE_REPEAT: begin
        repeat_held_next = 1'b1;
      end
      irpwd_pkg::PULSE_SEPARATOR: begin
        emit = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shift       <= '0;
      bit_count       <= '0;
      frame_started   <= 1'b0;
      repeat_held     <= 1'b0;
      latched_command <= '0;
    end else if (s1_valid && advance) begin
      bit_shift       <= bit_shift_next;
      bit_count       <= bit_count_next;
      frame_started   <= frame_started_next;
      repeat_held     <= repeat_held_next;
      latched_command <= latched_command_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && emit) begin
      command_word <= latched_command;
      repeat_seen  <= repeat_held;
    end
  end

endmodule
`default_nettype wire
